/* src/mrpt_pkg.sv */
// Shared constants and types for the Miller-Rabin primality tester.
`timescale 1ns / 1ps
package mrpt_pkg;

  localparam int NUM_BITS = 62;
  localparam int KW       = $clog2(NUM_BITS + 1);

  typedef logic [NUM_BITS-1:0] num_t;
  typedef logic [KW-1:0]       cnt_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECOMP,
    ST_MUL,
    ST_POW_STEP,
    ST_POW_SQR,
    ST_CHECK,
    ST_SQR_STEP,
    ST_SQR_TEST,
    ST_FINISH
  } state_t;

  typedef enum logic {
    DST_SQ,
    DST_RES
  } dst_t;

  localparam num_t NUM_ONE = {{(NUM_BITS-1){1'b0}}, 1'b1};
  localparam num_t NUM_TWO = {{(NUM_BITS-2){1'b0}}, 2'b10};

endpackage

/* src/miller_rabin_prime_test.sv */
// Miller-Rabin primality tester, two caller-supplied witnesses.
//
// Input channel: in_valid/in_ready with candidate, witness_first and
// witness_second. Output channel: out_valid/out_ready with is_prime.
// One result word comes back for every accepted input word.
// A candidate of 2 answers 1; one below 2 or even answers 0, both with
// no multiply. An odd candidate n runs n-1 = q*2^k decomposition (one
// shift a cycle), then for each witness: reduction mod n, a
// square-and-multiply power over the bits of q and up to k-1 squarings.
// Every modular multiply goes through one shared shift-and-add unit that
// handles one multiplier bit a cycle. Worst case is 2 * 123 multiplies,
// and a composite usually fails the first round.
// in_ready is high only while the sequencer is idle. The result sits in
// an output register, so the next word is taken while it waits; if the
// next answer is done before out_ready frees the register, the sequencer
// holds it. Synchronous reset empties the output register and idles the
// sequencer.
`timescale 1ns / 1ps
module miller_rabin_prime_test (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mrpt_pkg::num_t       candidate,
  input  mrpt_pkg::num_t       witness_first,
  input  mrpt_pkg::num_t       witness_second,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 is_prime
);
  import mrpt_pkg::*;

  state_t state, state_next, ret, ret_next;
  dst_t   dst, dst_next;
  num_t   n, n_next, top, top_next, w2, w2_next;
  num_t   q, q_next, expo, expo_next;
  num_t   sq, sq_next, res, res_next;
  num_t   acc, acc_next, addend, addend_next, bits, bits_next;
  cnt_t   k, k_next, cnt, cnt_next;
  logic   round, round_next, verdict, verdict_next;
  logic   out_valid_next, is_prime_next;

  logic [NUM_BITS:0] sum, dbl;

  assign in_ready = (state == ST_IDLE);
  assign sum = {1'b0, acc} + {1'b0, addend};
  assign dbl = {addend, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    ret      <= ret_next;
    dst      <= dst_next;
    n        <= n_next;
    top      <= top_next;
    w2       <= w2_next;
    q        <= q_next;
    expo     <= expo_next;
    sq       <= sq_next;
    res      <= res_next;
    acc      <= acc_next;
    addend   <= addend_next;
    bits     <= bits_next;
    k        <= k_next;
    cnt      <= cnt_next;
    round    <= round_next;
    verdict  <= verdict_next;
    is_prime <= is_prime_next;
  end

  always_comb begin
    logic   mul_go, round_go, pass_go, fail_go;
    num_t   mx, my, wsel;
    dst_t   md;
    state_t mr;

    mul_go   = 1'b0;
    round_go = 1'b0;
    pass_go  = 1'b0;
    fail_go  = 1'b0;
    mx       = NUM_ONE;
    my       = NUM_ONE;
    wsel     = w2;
    md       = DST_SQ;
    mr       = ST_POW_STEP;

    state_next     = state;
    ret_next       = ret;
    dst_next       = dst;
    n_next         = n;
    top_next       = top;
    w2_next        = w2;
    q_next         = q;
    expo_next      = expo;
    sq_next        = sq;
    res_next       = res;
    acc_next       = acc;
    addend_next    = addend;
    bits_next      = bits;
    k_next         = k;
    cnt_next       = cnt;
    round_next     = round;
    verdict_next   = verdict;
    out_valid_next = out_valid & ~out_ready;
    is_prime_next  = is_prime;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          n_next   = candidate;
          top_next = candidate - NUM_ONE;
          q_next   = candidate - NUM_ONE;
          w2_next  = witness_second;
          k_next   = '0;
          if (candidate == NUM_TWO) begin
            verdict_next = 1'b1;
            state_next   = ST_FINISH;
          end else if (candidate < NUM_TWO || !candidate[0]) begin
            verdict_next = 1'b0;
            state_next   = ST_FINISH;
          end else begin
            // hold the first witness in the reduction operand right away
            bits_next  = witness_first;
            state_next = ST_DECOMP;
          end
        end
      end
      ST_DECOMP: begin
        if (!q[0]) begin
          q_next = q >> 1;
          k_next = k + cnt_t'(1);
        end else begin
          round_next = 1'b0;
          round_go   = 1'b1;
          wsel       = bits;
        end
      end
      ST_MUL: begin
        if (bits == '0) begin
          if (dst == DST_SQ) begin
            sq_next = acc;
          end else begin
            res_next = acc;
          end
          state_next = ret;
        end else begin
          if (bits[0]) begin
            acc_next = (sum >= {1'b0, n}) ? num_t'(sum - {1'b0, n}) : num_t'(sum);
          end
          addend_next = (dbl >= {1'b0, n}) ? num_t'(dbl - {1'b0, n}) : num_t'(dbl);
          bits_next   = bits >> 1;
        end
      end
      ST_POW_STEP: begin
        if (expo == '0) begin
          state_next = ST_CHECK;
        end else if (expo[0]) begin
          mul_go = 1'b1;
          mx     = res;
          my     = sq;
          md     = DST_RES;
          mr     = ST_POW_SQR;
        end else begin
          state_next = ST_POW_SQR;
        end
      end
      ST_POW_SQR: begin
        expo_next = expo >> 1;
        mul_go    = 1'b1;
        mx        = sq;
        my        = sq;
        md        = DST_SQ;
        mr        = ST_POW_STEP;
      end
      ST_CHECK: begin
        if (res == NUM_ONE || res == top) begin
          pass_go = 1'b1;
        end else begin
          cnt_next   = cnt_t'(1);
          state_next = ST_SQR_STEP;
        end
      end
      ST_SQR_STEP: begin
        if (cnt < k) begin
          mul_go = 1'b1;
          mx     = res;
          my     = res;
          md     = DST_RES;
          mr     = ST_SQR_TEST;
        end else begin
          fail_go = 1'b1;
        end
      end
      ST_SQR_TEST: begin
        if (res == top) begin
          pass_go = 1'b1;
        end else begin
          cnt_next   = cnt + cnt_t'(1);
          state_next = ST_SQR_STEP;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          is_prime_next  = verdict;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (pass_go) begin
      if (!round) begin
        round_next = 1'b1;
        round_go   = 1'b1;
        wsel       = w2;
      end else begin
        verdict_next = 1'b1;
        state_next   = ST_FINISH;
      end
    end

    if (fail_go) begin
      verdict_next = 1'b0;
      state_next   = ST_FINISH;
    end

    // reduce the witness mod n by summing its bits times powers of two
    if (round_go) begin
      res_next  = NUM_ONE;
      expo_next = (state == ST_DECOMP) ? q : q;
      mul_go    = 1'b1;
      mx        = NUM_ONE;
      my        = wsel;
      md        = DST_SQ;
      mr        = ST_POW_STEP;
    end

    if (mul_go) begin
      acc_next    = '0;
      addend_next = mx;
      bits_next   = my;
      dst_next    = md;
      ret_next    = mr;
      state_next  = ST_MUL;
    end
  end

endmodule

/* test/miller_rabin_prime_test_tb.sv */
// Self-checking testbench for the Miller-Rabin primality tester.
`timescale 1ns / 1ps

// Predicts the verdict of each input word and checks the result words in order.
class verdict_board;
  bit pending_verdicts[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  // (x * y) mod n by shift and add, one multiplier bit per pass
  function logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] n);
    logic [63:0] acc;
    logic [63:0] addend;
    logic [63:0] bits;
    int i;
    acc = 0;
    addend = x % n;
    bits = y % n;
    for (i = 0; i < mrpt_pkg::NUM_BITS && bits != 0; i++) begin
      if (bits[0]) begin
        acc = acc + addend;
        if (acc >= n) acc = acc - n;
      end
      bits = bits >> 1;
      addend = addend << 1;
      if (addend >= n) addend = addend - n;
    end
    return acc;
  endfunction

  function logic [63:0] powmod(logic [63:0] base, logic [63:0] expo, logic [63:0] n);
    logic [63:0] acc;
    logic [63:0] sq;
    int i;
    acc = 64'd1 % n;
    sq = base % n;
    for (i = 0; i < mrpt_pkg::NUM_BITS && expo != 0; i++) begin
      if (expo[0]) acc = mulmod(acc, sq, n);
      expo = expo >> 1;
      sq = mulmod(sq, sq, n);
    end
    return acc;
  endfunction

  function bit round_passes(logic [63:0] a, logic [63:0] q, int k, logic [63:0] n);
    logic [63:0] t;
    int i;
    t = powmod(a, q, n);
    if (t == 1 || t == n - 1) return 1'b1;
    for (i = 1; i < k; i++) begin
      t = mulmod(t, t, n);
      if (t == n - 1) return 1'b1;
    end
    return 1'b0;
  endfunction

  function bit primality_verdict(logic [63:0] n, logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    int k;
    if (n == 2) return 1'b1;
    if (n < 2 || !n[0]) return 1'b0;
    q = n - 1;
    k = 0;
    while (!q[0] && k < mrpt_pkg::NUM_BITS) begin
      q = q >> 1;
      k++;
    end
    return round_passes(a, q, k, n) && round_passes(b, q, k, n);
  endfunction

  function void note_word(mrpt_pkg::num_t c, mrpt_pkg::num_t wa, mrpt_pkg::num_t wb);
    bit want;
    want = primality_verdict(c, wa, wb);
    pending_verdicts = {pending_verdicts, want};
  endfunction

  function void check_word(bit got);
    bit want;
    if (pending_verdicts.size() == 0) begin
      $display("%0t: is_prime expected none actual %0b", $time, got);
      errors++;
    end else begin
      want = pending_verdicts.pop_front();
      if (want != got) begin
        $display("%0t: is_prime expected %0b actual %0b", $time, want, got);
        errors++;
      end
    end
  endfunction

  function int pending();
    return pending_verdicts.size();
  endfunction
endclass

module miller_rabin_prime_test_tb;
  import mrpt_pkg::*;

  localparam int   WATCHDOG_LIMIT = 200000;
  localparam num_t ALL_ONES       = '1;
  localparam num_t ALT_BITS       = {31{2'b10}};
  localparam num_t TOP_PRIME      = 62'd4611686018427387847;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_ready;
  num_t candidate      = '0;
  num_t witness_first  = '0;
  num_t witness_second = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic is_prime;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_count    = 0;

  verdict_board board = new();

  miller_rabin_prime_test u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .candidate      (candidate),
    .witness_first  (witness_first),
    .witness_second (witness_second),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .is_prime       (is_prime)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_word(is_prime);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic num_t rand_num();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[61:0];
  endfunction

  // Odd value with its top bit set; mostly short so the multiplies stay quick
  function automatic num_t sized_odd();
    int b;
    num_t v;
    b = ($urandom_range(9) < 2) ? $urandom_range(62, 40) : $urandom_range(24, 3);
    v = rand_num() & (ALL_ONES >> (62 - b));
    v[b-1] = 1'b1;
    v[0] = 1'b1;
    return v;
  endfunction

  function automatic num_t base_in_range(num_t n);
    if (n < 5) return NUM_TWO;
    return NUM_TWO + rand_num() % (n - 3);
  endfunction

  // Witness mostly outside 2..n-2: zero, one, n-1, n and beyond, or random
  function automatic num_t stray_base(num_t n);
    case ($urandom_range(6))
      0: return '0;
      1: return NUM_ONE;
      2: return n - 1;
      3: return n;
      4: return n + num_t'($urandom_range(1000, 1));
      5: return rand_num();
      default: return ALL_ONES;
    endcase
  endfunction

  task automatic make_word(output num_t c, output num_t wa, output num_t wb);
    int sel;
    int tries;
    sel = $urandom_range(99);
    tries = 0;
    c = sized_odd();
    // hunt for a probable prime so that both verdicts show up often
    if (sel < 45) begin
      while (!board.primality_verdict(c, 2, 3) && tries < 400) begin
        c = sized_odd();
        tries++;
      end
    end
    wa = base_in_range(c);
    wb = base_in_range(c);
    if (sel >= 75 && sel < 88) begin
      wa = stray_base(c);
      if ($urandom_range(1)) wb = stray_base(c);
    end else if (sel >= 88) begin
      c = rand_num() >> $urandom_range(61, 0);
      wa = rand_num();
      wb = rand_num();
    end
  endtask

  task automatic send_word(input num_t c, input num_t wa, input num_t wb);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    candidate      <= c;
    witness_first  <= wa;
    witness_second <= wb;
    do @(posedge clk); while (!in_ready);
    board.note_word(c, wa, wb);
  endtask

  // Hold the sender off until every outstanding word has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic run_random(input int idle_pct, input int stall_pct, input int count);
    num_t c;
    num_t wa;
    num_t wb;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      make_word(c, wa, wb);
      send_word(c, wa, wb);
    end
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_word('0, NUM_TWO, NUM_TWO);
    send_word(NUM_ONE, ALL_ONES, '0);
    send_word(NUM_TWO, '0, '0);
    send_word(NUM_TWO, ALL_ONES, ALT_BITS);
    send_word(62'd4, 62'd2, 62'd3);
    send_word(62'd3, 62'd2, 62'd2);
    send_word(62'd3, '0, NUM_ONE);
    send_word(62'd5, 62'd2, 62'd3);
    send_word(62'd7, 62'd3, 62'd5);
    send_word(62'd7, 62'd8, 62'd13);
    send_word(62'd9, 62'd2, 62'd4);
    send_word(62'd561, 62'd2, 62'd5);
    // strong pseudoprime to base 2
    send_word(62'd2047, 62'd2, 62'd2);
    send_word(62'd2047, 62'd2, 62'd3);
    send_word(TOP_PRIME, 62'd2, 62'd3);
    send_word(TOP_PRIME, NUM_ONE, TOP_PRIME - 1);
    send_word(TOP_PRIME, TOP_PRIME, 62'd5);
    send_word(TOP_PRIME, ALL_ONES, ~ALT_BITS);
    send_word(ALL_ONES, ALL_ONES, NUM_TWO);
    send_word(ALL_ONES - 1, ALT_BITS, ~ALT_BITS);
    send_word(~ALT_BITS, ALT_BITS, 62'd7);
    drain();

    run_random(0, 0, 25);
    run_random(71, 0, 25);
    run_random(0, 71, 25);
    run_random(17, 17, 25);

    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
